// ===== rtl/rgba_box_downscale_4x4_macros.svh =====
// assertion macros for the rgba box downscaler
// used by rgba_box_downscale_4x4, expects clk and rst_n in scope
`ifndef RGBA_BOX_DOWNSCALE_4X4_MACROS_SVH
`define RGBA_BOX_DOWNSCALE_4X4_MACROS_SVH

// same-cycle implication, off during reset
`define RBD_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("rbd assertion failed");

// next-cycle implication, off during reset
`define RBD_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("rbd assertion failed");

`endif

// ===== rtl/rbd_pkg.sv =====
// shared types and constants for the rgba box downscaler
// no dependencies
package rbd_pkg;

  localparam int CH_W       = 8;
  localparam int RUN_W      = 10;
  localparam int BAND_W     = 12;
  localparam int N_CH       = 4;
  localparam int LINE_W     = N_CH * BAND_W;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int OSIZE_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_MIN = 13'd4;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [RUN_W-1:0]  run_t;
  typedef logic [BAND_W-1:0] band_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    logic  row_end;
    logic  frame_end;
  } res_t;

  // clamp a size register into the supported range
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/rbd_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rbd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rgba_box_downscale_4x4.sv =====
// 4x4 box downscaler: one rgba source pixel a cycle while in_stall is low, one averaged pixel per block
// the result is registered, in the output or the skid stage, at the edge that takes the last pixel of its block
// throughput: one pixel every cycle; input stalls only while a second result waits behind out
// the line ram is read on each pixel and written on the fourth pixel of a quad
// reset: position, run sums and the output and skid valid flags clear; sizes go to 4x4;
// line ram contents are not cleared, each entry is rewritten on the first row of its band
`include "rgba_box_downscale_4x4_macros.svh"

module rgba_box_downscale_4x4 #(
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data,
  // source pixels
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rbd_pkg::CH_W-1:0]       in_pix_red,
  input  logic [rbd_pkg::CH_W-1:0]       in_pix_green,
  input  logic [rbd_pkg::CH_W-1:0]       in_pix_blue,
  input  logic [rbd_pkg::CH_W-1:0]       in_pix_alpha,
  // output pixels
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rbd_pkg::CH_W-1:0]       out_red,
  output logic [rbd_pkg::CH_W-1:0]       out_green,
  output logic [rbd_pkg::CH_W-1:0]       out_blue,
  output logic [rbd_pkg::CH_W-1:0]       out_alpha,
  output logic                           out_row_end,
  output logic                           out_frame_end
);

  localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int OW_CAP = (MAX_OUT_WIDTH < 1024) ? MAX_OUT_WIDTH : 1024;

  // size registers, kept clamped
  logic [rbd_pkg::SIZE_W-1:0]  w_eff_r, h_eff_r;
  logic [rbd_pkg::OSIZE_W-1:0] ow_r, oh_r;
  logic [rbd_pkg::OSIZE_W-1:0] ow_nxt, oh_nxt;
  logic [rbd_pkg::SIZE_W-1:0]  cfg_clamped;
  logic                        cfg_acc;

  // position and running quad sums
  logic [rbd_pkg::POS_W-1:0] col_pos_r, row_pos_r;
  logic [rbd_pkg::POS_W-1:0] col_pos_nxt, row_pos_nxt;
  rbd_pkg::run_t             run_r   [rbd_pkg::N_CH];
  rbd_pkg::run_t             run_nxt [rbd_pkg::N_CH];
  rbd_pkg::band_t            band_new [rbd_pkg::N_CH];
  rbd_pkg::chan_t            pix [rbd_pkg::N_CH];

  logic                      in_acc, active, quad_end, emit;
  logic [11:0]               bx12, by12;
  logic [rbd_pkg::LINE_W-1:0] line_rd, line_wr;
  logic                      mem_we;

  // output register and skid stage
  rbd_pkg::res_t res, out_r, out_nxt, skid_r, skid_nxt;
  logic          out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic          out_take, gen;

  // ---------------- configuration ----------------
  assign cfg_ready   = 1'b1;
  assign cfg_acc     = cfg_valid && cfg_ready;
  assign cfg_clamped = rbd_pkg::clamp_size(cfg_data);

  always_comb begin
    logic [rbd_pkg::OSIZE_W-1:0] q;
    q = cfg_clamped[rbd_pkg::SIZE_W-1:2];
    ow_nxt = (q > rbd_pkg::OSIZE_W'(OW_CAP)) ? rbd_pkg::OSIZE_W'(OW_CAP) : q;
    oh_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= rbd_pkg::SIZE_MIN;
      h_eff_r <= rbd_pkg::SIZE_MIN;
      ow_r    <= rbd_pkg::OSIZE_W'(1);
      oh_r    <= rbd_pkg::OSIZE_W'(1);
    end else if (cfg_acc) begin
      case (cfg_index)
        rbd_pkg::CFG_SOURCE_WIDTH: begin
          w_eff_r <= cfg_clamped;
          ow_r    <= ow_nxt;
        end
        rbd_pkg::CFG_SOURCE_HEIGHT: begin
          h_eff_r <= cfg_clamped;
          oh_r    <= oh_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- datapath ----------------
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  assign pix[0] = in_pix_red;
  assign pix[1] = in_pix_green;
  assign pix[2] = in_pix_blue;
  assign pix[3] = in_pix_alpha;

  assign bx12     = {2'b00, col_pos_r[rbd_pkg::POS_W-1:2]};
  assign by12     = {2'b00, row_pos_r[rbd_pkg::POS_W-1:2]};
  assign active   = ({1'b0, bx12[9:0]} < ow_r) && ({1'b0, by12[9:0]} < oh_r);
  assign quad_end = (col_pos_r[1:0] == 2'b11);
  assign mem_we   = in_acc && active && quad_end;
  assign emit     = active && quad_end && (row_pos_r[1:0] == 2'b11);

  // quad sum and band sum for this beat
  always_comb begin
    for (int k = 0; k < rbd_pkg::N_CH; k++) begin
      if (col_pos_r[1:0] == 2'b00) begin
        run_nxt[k] = {2'b00, pix[k]};
      end else begin
        run_nxt[k] = run_r[k] + {2'b00, pix[k]};
      end
      if (row_pos_r[1:0] == 2'b00) begin
        band_new[k] = {2'b00, run_nxt[k]};
      end else begin
        band_new[k] = line_rd[k*rbd_pkg::BAND_W +: rbd_pkg::BAND_W] + {2'b00, run_nxt[k]};
      end
      line_wr[k*rbd_pkg::BAND_W +: rbd_pkg::BAND_W] = band_new[k];
    end
  end

  // next position
  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if ({1'b0, col_pos_r} + 13'd1 >= w_eff_r) begin
      col_pos_nxt = '0;
      if ({1'b0, row_pos_r} + 13'd1 >= h_eff_r) begin
        row_pos_nxt = '0;
      end else begin
        row_pos_nxt = row_pos_r + 12'd1;
      end
    end else begin
      col_pos_nxt = col_pos_r + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      for (int k = 0; k < rbd_pkg::N_CH; k++) begin
        run_r[k] <= '0;
      end
    end else if (in_acc) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      if (active) begin
        for (int k = 0; k < rbd_pkg::N_CH; k++) begin
          run_r[k] <= run_nxt[k];
        end
      end
    end
  end

  // line of band sums; read every beat so the entry for a quad is ready
  // when its last pixel arrives, written on that last pixel
  rbd_ram #(
    .W     (rbd_pkg::LINE_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (bx12[AW-1:0]),
    .wdata (line_wr),
    .re    (in_acc),
    .raddr (bx12[AW-1:0]),
    .rdata (line_rd)
  );

  // ---------------- result staging ----------------
  always_comb begin
    res.red       = band_new[0][rbd_pkg::BAND_W-1:4];
    res.green     = band_new[1][rbd_pkg::BAND_W-1:4];
    res.blue      = band_new[2][rbd_pkg::BAND_W-1:4];
    res.alpha     = band_new[3][rbd_pkg::BAND_W-1:4];
    res.row_end   = ({1'b0, bx12[9:0]} == ow_r - 11'd1);
    res.frame_end = res.row_end && ({1'b0, by12[9:0]} == oh_r - 11'd1);
  end

  assign out_take = out_valid_r && !out_stall;
  assign gen      = in_acc && emit;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (gen) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_r.red;
  assign out_green     = out_r.green;
  assign out_blue      = out_r.blue;
  assign out_alpha     = out_r.alpha;
  assign out_row_end   = out_r.row_end;
  assign out_frame_end = out_r.frame_end;

  // ---------------- assertions ----------------
  `RBD_ASSERT_IMPLY(a_skid_behind_out, skid_valid_r, out_valid_r)
  `RBD_ASSERT_NEXT(a_result_staged, gen, out_valid_r)
  `RBD_ASSERT_IMPLY(a_line_addr_range, mem_we, ({1'b0, bx12[9:0]} < ow_r))
  `RBD_ASSERT_NEXT(a_skid_fills_on_stall, gen && out_valid_r && out_stall, skid_valid_r)

endmodule

// ===== test/rgba_box_downscale_4x4_tb.sv =====
// self-checking testbench for rgba_box_downscale_4x4: 4x4 box averaging of rgba pixels
// a local model of the line sums predicts each output pixel; needs rbd_pkg and the rtl
module rgba_box_downscale_4x4_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OUT     = 1024;
  localparam int N_DIR       = 24;
  localparam int N_ITEMS     = 1400;
  localparam int QUIET_TAIL  = 250;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    rbd_pkg::chan_t red;
    rbd_pkg::chan_t green;
    rbd_pkg::chan_t blue;
    rbd_pkg::chan_t alpha;
  } pix_t;

  typedef struct packed {
    pix_t          px;
    logic          typed;
    rbd_pkg::res_t want;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rbd_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  rbd_pkg::chan_t                 in_pix_red;
  rbd_pkg::chan_t                 in_pix_green;
  rbd_pkg::chan_t                 in_pix_blue;
  rbd_pkg::chan_t                 in_pix_alpha;
  logic                           out_valid;
  logic                           out_stall;
  rbd_pkg::chan_t                 out_red;
  rbd_pkg::chan_t                 out_green;
  rbd_pkg::chan_t                 out_blue;
  rbd_pkg::chan_t                 out_alpha;
  logic                           out_row_end;
  logic                           out_frame_end;

  // local copy of the block state
  logic [rbd_pkg::CFG_DATA_W-1:0] width_reg;
  logic [rbd_pkg::CFG_DATA_W-1:0] height_reg;
  int                             col_at;
  int                             row_at;
  rbd_pkg::run_t                  quad_sum [0:rbd_pkg::N_CH-1];
  rbd_pkg::band_t                 column_sums [0:MAX_OUT-1][0:rbd_pkg::N_CH-1];

  rbd_pkg::res_t averaged_pixels_due [$];
  int   errors;
  int   sent;
  bit   idle_on;
  bit   drained_once;
  int   quiet_cycles;

  rgba_box_downscale_4x4 #(
    .MAX_OUT_WIDTH(MAX_OUT)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pix_red   (in_pix_red),
    .in_pix_green (in_pix_green),
    .in_pix_blue  (in_pix_blue),
    .in_pix_alpha (in_pix_alpha),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .out_row_end  (out_row_end),
    .out_frame_end(out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic int fit_size(input logic [rbd_pkg::CFG_DATA_W-1:0] v);
    int s;
    s = int'(v);
    if (s < int'(rbd_pkg::SIZE_MIN)) begin
      s = int'(rbd_pkg::SIZE_MIN);
    end else if (s > int'(rbd_pkg::SIZE_MAX)) begin
      s = int'(rbd_pkg::SIZE_MAX);
    end
    return s;
  endfunction

  // one source pixel into the local model; returns 1 when it closes a whole block
  function automatic bit box_average_step(input pix_t p, output rbd_pkg::res_t r);
    int             w, h, ow, oh, bx, by, k;
    rbd_pkg::chan_t ch [0:rbd_pkg::N_CH-1];
    bit             hit;
    w  = fit_size(width_reg);
    h  = fit_size(height_reg);
    ow = w / 4;
    oh = h / 4;
    if (ow > MAX_OUT) ow = MAX_OUT;
    bx = col_at / 4;
    by = row_at / 4;
    ch[0] = p.red;
    ch[1] = p.green;
    ch[2] = p.blue;
    ch[3] = p.alpha;
    hit = 1'b0;
    r = '0;
    if (bx < ow && by < oh) begin
      for (k = 0; k < rbd_pkg::N_CH; k++) begin
        if (col_at % 4 == 0) quad_sum[k] = {2'b00, ch[k]};
        else quad_sum[k] = quad_sum[k] + {2'b00, ch[k]};
      end
      if (col_at % 4 == 3) begin
        for (k = 0; k < rbd_pkg::N_CH; k++) begin
          if (row_at % 4 == 0) column_sums[bx][k] = {2'b00, quad_sum[k]};
          else column_sums[bx][k] = column_sums[bx][k] + {2'b00, quad_sum[k]};
        end
        if (row_at % 4 == 3) begin
          r.red       = column_sums[bx][0][rbd_pkg::BAND_W-1:4];
          r.green     = column_sums[bx][1][rbd_pkg::BAND_W-1:4];
          r.blue      = column_sums[bx][2][rbd_pkg::BAND_W-1:4];
          r.alpha     = column_sums[bx][3][rbd_pkg::BAND_W-1:4];
          r.row_end   = (bx == ow - 1);
          r.frame_end = (bx == ow - 1) && (by == oh - 1);
          hit = 1'b1;
        end
      end
    end
    if (col_at + 1 >= w) begin
      col_at = 0;
      row_at = (row_at + 1 >= h) ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
    return hit;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    case ($urandom_range(0, 7))
      0: p = '1;
      1: p = '0;
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic send_pixel(input pix_t p, input bit typed, input rbd_pkg::res_t want);
    rbd_pkg::res_t predicted;
    bit            hit;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pix_red   <= p.red;
    in_pix_green <= p.green;
    in_pix_blue  <= p.blue;
    in_pix_alpha <= p.alpha;
    do @(posedge clk); while (in_stall);
    sent++;
    hit = box_average_step(p, predicted);
    if (typed) begin
      if (!hit) report("directed row should close a block");
      averaged_pixels_due.push_back(want);
    end else if (hit) begin
      averaged_pixels_due.push_back(predicted);
    end
  endtask

  // sender holds off until every pending output pixel has come out
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (averaged_pixels_due.size() != 0) @(posedge clk);
  endtask

  task automatic finish_frame();
    rbd_pkg::res_t none;
    none = '0;
    while (col_at != 0 || row_at != 0) send_pixel(rand_pixel(), 1'b0, none);
  endtask

  task automatic run_pixels(input int n);
    rbd_pkg::res_t none;
    int            i;
    none = '0;
    for (i = 0; i < n; i++) begin
      send_pixel(rand_pixel(), 1'b0, none);
      if (averaged_pixels_due.size() != 0 && (!drained_once || $urandom_range(0, 149) == 0)) begin
        drain();
        drained_once = 1'b1;
      end
    end
  endtask

  // writes both sizes with nothing in flight, the position is left where it is
  task automatic write_sizes(input logic [rbd_pkg::CFG_DATA_W-1:0] new_w,
                             input logic [rbd_pkg::CFG_DATA_W-1:0] new_h);
    logic [rbd_pkg::CFG_IDX_W-1:0]  idx [0:1];
    logic [rbd_pkg::CFG_DATA_W-1:0] val [0:1];
    int                             first, n, k;
    idx[0] = rbd_pkg::CFG_SOURCE_WIDTH;
    idx[1] = rbd_pkg::CFG_SOURCE_HEIGHT;
    val[0] = new_w;
    val[1] = new_h;
    first  = $urandom_range(0, 1);
    drain();
    // a trailing partial band may still be in the pipe
    repeat (4) @(posedge clk);
    for (n = 0; n < 2; n++) begin
      k = (first + n) % 2;
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      if (idx[k] == rbd_pkg::CFG_SOURCE_WIDTH) width_reg = val[k];
      else height_reg = val[k];
    end
    cfg_valid <= 1'b0;
  endtask

  // sizes change only at a frame boundary with nothing in flight
  task automatic set_size(input logic [rbd_pkg::CFG_DATA_W-1:0] new_w,
                          input logic [rbd_pkg::CFG_DATA_W-1:0] new_h);
    finish_frame();
    write_sizes(new_w, new_h);
  endtask

  always @(posedge clk) begin : check_output
    rbd_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (averaged_pixels_due.size() == 0) begin
        report("output pixel with none pending");
      end else begin
        want = averaged_pixels_due.pop_front();
        if (out_red !== want.red)
          report($sformatf("red got %0d want %0d", out_red, want.red));
        if (out_green !== want.green)
          report($sformatf("green got %0d want %0d", out_green, want.green));
        if (out_blue !== want.blue)
          report($sformatf("blue got %0d want %0d", out_blue, want.blue));
        if (out_alpha !== want.alpha)
          report($sformatf("alpha got %0d want %0d", out_alpha, want.alpha));
        if (out_row_end !== want.row_end)
          report($sformatf("row_end got %0b want %0b", out_row_end, want.row_end));
        if (out_frame_end !== want.frame_end)
          report($sformatf("frame_end got %0b want %0b", out_frame_end, want.frame_end));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[rgba_box_downscale_4x4] ERROR");
      $finish;
    end
  end

  initial begin : out_backpressure
    int left;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!idle_on) left = 0;
      else if (left == 0 && $urandom_range(0, 7) == 0) left = $urandom_range(1, 19);
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    dir_row_t                       dir_rows [0:N_DIR-1];
    logic [rbd_pkg::CFG_DATA_W-1:0] w, h;
    int                             i;

    // first frame at the reset size 4x4: every pixel alike, so the mean is the pixel
    //             red    green  blue   alpha  typed  red    green  blue   alpha  row  frame
    dir_rows[0]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[1]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[2]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[3]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[4]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[5]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[6]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[7]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[8]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[9]  = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[10] = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[11] = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[12] = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[13] = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[14] = {8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[15] = {8'hff, 8'h00, 8'hff, 8'h00, 1'b1, 8'hff, 8'h00, 8'hff, 8'h00, 1'b1, 1'b1};
    // second frame, first two rows: alternating bit patterns, checked by the model
    dir_rows[16] = {8'h80, 8'h7f, 8'h01, 8'hfe, 1'b0, 34'h0};
    dir_rows[17] = {8'h7f, 8'h80, 8'hfe, 8'h01, 1'b0, 34'h0};
    dir_rows[18] = {8'h55, 8'haa, 8'hff, 8'h00, 1'b0, 34'h0};
    dir_rows[19] = {8'haa, 8'h55, 8'h00, 8'hff, 1'b0, 34'h0};
    dir_rows[20] = {8'h01, 8'hfe, 8'h80, 8'h7f, 1'b0, 34'h0};
    dir_rows[21] = {8'hfe, 8'h01, 8'h7f, 8'h80, 1'b0, 34'h0};
    dir_rows[22] = {8'h00, 8'hff, 8'h55, 8'haa, 1'b0, 34'h0};
    dir_rows[23] = {8'hff, 8'h00, 8'haa, 8'h55, 1'b0, 34'h0};

    width_reg    = rbd_pkg::SIZE_MIN;
    height_reg   = rbd_pkg::SIZE_MIN;
    col_at       = 0;
    row_at       = 0;
    errors       = 0;
    sent         = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    drained_once = 1'b0;
    for (i = 0; i < rbd_pkg::N_CH; i++) quad_sum[i] = '0;

    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= rbd_pkg::CFG_SOURCE_WIDTH;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_pix_red   <= '0;
    in_pix_green <= '0;
    in_pix_blue  <= '0;
    in_pix_alpha <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++)
      send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);

    // widest frame (all-ones clamps to 4096, zero to 4): four quads of the first row
    set_size(13'h1fff, 13'h0000);
    run_pixels(16);
    // shrink to 4 wide, tallest frame: position past the width wraps into row 1,
    // rows 1 to 3 finish the band started by the first wide quad
    write_sizes(13'h0000, 13'h1fff);
    run_pixels(29);
    // at a band boundary past the new height: the rest of the row is dropped
    write_sizes(13'h0004, 13'h0003);

    while (sent < N_ITEMS) begin
      idle_on = (sent < N_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: w = rbd_pkg::CFG_DATA_W'($urandom_range(0, 3));
        1: w = rbd_pkg::SIZE_MIN;
        default: w = rbd_pkg::CFG_DATA_W'($urandom_range(5, 24));
      endcase
      if ($urandom_range(0, 4) == 0) h = rbd_pkg::CFG_DATA_W'($urandom_range(0, 3));
      else h = rbd_pkg::CFG_DATA_W'($urandom_range(4, 12));
      set_size(w, h);
      run_pixels($urandom_range(20, 150));
    end
    finish_frame();

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[rgba_box_downscale_4x4] OK");
    end else begin
      $display("[rgba_box_downscale_4x4] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rbd_pkg.sv
rtl/rbd_ram.sv
rtl/rgba_box_downscale_4x4.sv
test/rgba_box_downscale_4x4_tb.sv
